@@ rtl/tlzd_pkg.sv @@
// shared types and constants for the texture element lz decompressor
`default_nettype none

package tlzd_pkg;

    localparam int unsigned MAX_ELEMS_DEF = 262144;

    localparam int unsigned ELEM_W  = 32;
    localparam int unsigned POS_W   = 19;
    localparam int unsigned IDX_W   = 18;
    localparam int unsigned OFF_W   = 18;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned ALU_W   = 20;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [POS_W-1:0] FRAME_RESET = 19'h40000;
    localparam int unsigned      FRAME_MIN   = 2;

    localparam int unsigned OFF_BASE8  = 2;
    localparam int unsigned OFF_BASE16 = 'h102;
    localparam int unsigned OFF_CODE1  = 2;
    localparam int unsigned CODES_PER_WORD = 16;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_HDR_SHORT = 3'd1,
        ST_TOP_FAIL  = 3'd2,
        ST_NEST_FAIL = 3'd3,
        ST_LIT_SHORT = 3'd4
    } t_status;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             carry;
    } t_alu_rsp;

    typedef struct packed {
        logic              wr_en;
        logic [POS_W-1:0]  wr_addr;
        logic [ELEM_W-1:0] wr_data;
        logic              rd_en;
        logic [POS_W-1:0]  rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic [ELEM_W-1:0] value;
        logic [IDX_W-1:0]  index;
        logic              done;
        t_status           status;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/texture_lz_element_decompressor.sv @@
// texture element lz decompressor: one compressed byte in, decoded 32-bit elements out
// a byte that only gathers returns the block to byte input (or to the end state when it ends the stream too soon)
// each emitted element is written through the put state, each copied element first through the history read
// a control word that releases 32 copies is worked off in the code sequencer
// the block takes no byte while the sequencer works; one output register holds the last result
// synchronous active-low reset; the history memory is not cleared and needs no clearing pass
`default_nettype none

module texture_lz_element_decompressor #(
    parameter int unsigned MAX_ELEMS = tlzd_pkg::MAX_ELEMS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [18:0] i_cfg_wr_data,   // frame_elements
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,    // stream_byte
    input  wire         s_axis_tlast,    // stream_end
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata,    // element_value [31:0], element_index [49:32], zero pad
    output logic        m_axis_tlast,    // frame_done
    output logic [2:0]  m_axis_tuser     // status
);

    localparam int unsigned MaxCmp = (MAX_ELEMS > 524287) ? 524287 : MAX_ELEMS;

    logic [tlzd_pkg::POS_W-1:0] r_frame_elems;
    logic [tlzd_pkg::POS_W-1:0] total;

    logic                        res_valid;
    logic                        res_ready;
    tlzd_pkg::t_result           res;
    tlzd_pkg::t_mem_req          mem_req;
    logic [tlzd_pkg::ELEM_W-1:0] mem_rdata;
    tlzd_pkg::t_alu_req          alu_req;
    tlzd_pkg::t_alu_rsp          alu_rsp;

    logic                        r_out_valid;
    tlzd_pkg::t_result           r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_elems <= tlzd_pkg::FRAME_RESET;
        end else if (i_cfg_wr_en) begin
            r_frame_elems <= i_cfg_wr_data;
        end
    end

    // clamp frame size into the supported range
    always_comb begin
        if (r_frame_elems < tlzd_pkg::POS_W'(tlzd_pkg::FRAME_MIN)) begin
            total = tlzd_pkg::POS_W'(tlzd_pkg::FRAME_MIN);
        end else if (r_frame_elems > tlzd_pkg::POS_W'(MaxCmp)) begin
            total = tlzd_pkg::POS_W'(MaxCmp);
        end else begin
            total = r_frame_elems;
        end
    end

    tlzd_ctrl #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_end       (s_axis_tlast),
        .i_total     (total),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_mem       (mem_req),
        .i_mem_rdata (mem_rdata),
        .o_alu       (alu_req),
        .i_alu       (alu_rsp)
    );

    tlzd_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    tlzd_hist_mem #(
        .DEPTH (MAX_ELEMS)
    ) u_hist (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (mem_rdata)
    );

    // output register, refilled in the cycle it is emptied
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out.index, r_out.value};
    assign m_axis_tlast  = r_out.done;
    assign m_axis_tuser  = r_out.status;

    a_err_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != tlzd_pkg::ST_OK)
        |-> (r_out.done && r_out.value == '0))
        else $error("error transfer without frame end or with nonzero value");

    a_ready_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !res_valid)
        else $error("byte accepted while a result is still staged");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("staged result dropped before transfer");

endmodule

`default_nettype wire

@@ rtl/tlzd_alu.sv @@
// shared add/subtract unit used by the decode sequencer
`default_nettype none

module tlzd_alu (
    input  tlzd_pkg::t_alu_req i_req,
    output tlzd_pkg::t_alu_rsp o_rsp
);

    logic [tlzd_pkg::ALU_W:0] sum;

    always_comb begin
        if (i_req.op == tlzd_pkg::ALU_ADD) begin
            sum = {1'b0, i_req.a} + {1'b0, i_req.b};
        end else begin
            sum = {1'b0, i_req.a} - {1'b0, i_req.b};
        end
    end

    // carry doubles as borrow for subtraction
    assign o_rsp.res   = sum[tlzd_pkg::ALU_W-1:0];
    assign o_rsp.carry = sum[tlzd_pkg::ALU_W];

endmodule

`default_nettype wire

@@ rtl/tlzd_hist_mem.sv @@
// history memory of decoded elements, one write and one registered read port
`default_nettype none

module tlzd_hist_mem #(
    parameter int unsigned DEPTH = tlzd_pkg::MAX_ELEMS_DEF
) (
    input  wire                           i_clk,
    input  tlzd_pkg::t_mem_req            i_req,
    output logic [tlzd_pkg::ELEM_W-1:0]   o_rd_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [tlzd_pkg::ELEM_W-1:0] mem [DEPTH];
    logic [tlzd_pkg::ELEM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[AW'(i_req.wr_addr)] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[AW'(i_req.rd_addr)];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/tlzd_ctrl.sv @@
// decode sequencer: byte gathering, code walk, copies and result staging
`default_nettype none

module tlzd_ctrl #(
    parameter int unsigned MAX_ELEMS = tlzd_pkg::MAX_ELEMS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire  [tlzd_pkg::BYTE_W-1:0]    i_byte,
    input  wire                            i_end,
    input  wire  [tlzd_pkg::POS_W-1:0]     i_total,
    output logic                           o_res_valid,
    output tlzd_pkg::t_result              o_res,
    input  wire                            i_res_ready,
    output tlzd_pkg::t_mem_req             o_mem,
    input  wire  [tlzd_pkg::ELEM_W-1:0]    i_mem_rdata,
    output tlzd_pkg::t_alu_req             o_alu,
    input  tlzd_pkg::t_alu_rsp             i_alu
);

    typedef enum logic [2:0] {
        S_IN, S_OFF, S_CHK, S_RUN, S_RD, S_PUT, S_END
    } t_state;

    typedef enum logic [2:0] {
        PH_HDR0, PH_HDR1, PH_CTRL, PH_OFF8, PH_OFF16, PH_LIT, PH_DRAIN
    } t_phase;

    typedef enum logic [2:0] {
        ACT_TOP, ACT_CODE, ACT_COPY, ACT_COPY2, ACT_NEST, ACT_END
    } t_act;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    t_act   r_act,   n_act;

    logic [tlzd_pkg::POS_W-1:0]  r_wp,     n_wp;
    logic [tlzd_pkg::OFF_W-1:0]  r_off,    n_off;
    logic [31:0]                 r_ctrl,   n_ctrl;
    logic [4:0]                  r_codes,  n_codes;
    logic [31:0]                 r_gather, n_gather;
    logic [2:0]                  r_gc,     n_gc;
    logic [1:0]                  r_nest,   n_nest;
    logic                        r_end,    n_end;
    logic                        r_done,   n_done;
    logic                        r_err,    n_err;
    logic                        r_pend_v, n_pend_v;
    tlzd_pkg::t_result           r_pend,   n_pend;
    logic [tlzd_pkg::ELEM_W-1:0] r_val,    n_val;
    logic                        r_from_mem, n_from_mem;

    logic [31:0]                 gathered;
    logic [2:0]                  gc_inc;
    logic [2:0]                  need;
    logic [tlzd_pkg::ELEM_W-1:0] put_value;
    logic                        pos_ok;
    tlzd_pkg::t_status           end_status;
    tlzd_pkg::t_status           off_status;

    assign pos_ok   = 32'(r_wp) < 32'(MAX_ELEMS);
    assign gathered = r_gather | (32'(i_byte) << {r_gc[1:0], 3'b000});
    assign gc_inc   = r_gc + 3'd1;
    assign put_value = r_from_mem ? i_mem_rdata : r_val;
    assign off_status = (r_nest == 2'd0) ? tlzd_pkg::ST_TOP_FAIL : tlzd_pkg::ST_NEST_FAIL;

    always_comb begin
        case (r_phase)
            PH_OFF8:  need = 3'd1;
            PH_OFF16: need = 3'd2;
            default:  need = 3'd4;
        endcase
    end

    always_comb begin
        case (r_phase) inside
            PH_HDR0, PH_HDR1: end_status = tlzd_pkg::ST_HDR_SHORT;
            PH_LIT:           end_status = tlzd_pkg::ST_LIT_SHORT;
            default:          end_status = off_status;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_act      = r_act;
        n_wp       = r_wp;
        n_off      = r_off;
        n_ctrl     = r_ctrl;
        n_codes    = r_codes;
        n_gather   = r_gather;
        n_gc       = r_gc;
        n_nest     = r_nest;
        n_end      = r_end;
        n_done     = r_done;
        n_err      = r_err;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        n_val      = r_val;
        n_from_mem = r_from_mem;

        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_res       = r_pend;
        o_mem       = '0;
        o_alu.op    = tlzd_pkg::ALU_SUB;
        o_alu.a     = tlzd_pkg::ALU_W'(r_wp);
        o_alu.b     = tlzd_pkg::ALU_W'(r_off);

        case (r_state)
            S_IN: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_end  = i_end;
                    n_done = 1'b0;
                    n_err  = 1'b0;
                    if (r_phase == PH_DRAIN) begin
                        if (i_end) begin
                            n_wp     = '0;
                            n_off    = '0;
                            n_ctrl   = '0;
                            n_codes  = '0;
                            n_gather = '0;
                            n_gc     = '0;
                            n_phase  = PH_HDR0;
                            n_nest   = '0;
                        end
                    end else if (gc_inc == need) begin
                        n_gather   = '0;
                        n_gc       = '0;
                        n_val      = gathered;
                        n_from_mem = 1'b0;
                        case (r_phase)
                            PH_HDR0: begin
                                n_phase = PH_HDR1;
                                n_act   = ACT_END;
                                n_state = S_PUT;
                            end
                            PH_HDR1: begin
                                n_act   = ACT_TOP;
                                n_state = S_PUT;
                            end
                            PH_CTRL: begin
                                n_ctrl  = gathered;
                                n_codes = 5'(tlzd_pkg::CODES_PER_WORD);
                                n_act   = ACT_CODE;
                                n_state = S_RUN;
                            end
                            PH_OFF8, PH_OFF16: begin
                                n_gather = gathered;
                                n_state  = S_OFF;
                            end
                            PH_LIT: begin
                                n_act   = ACT_NEST;
                                n_state = S_PUT;
                            end
                            default: n_state = S_IN;
                        endcase
                    end else begin
                        n_gather = gathered;
                        n_gc     = gc_inc;
                        n_state  = i_end ? S_END : S_IN;
                    end
                end
            end

            S_OFF: begin
                o_alu.op = tlzd_pkg::ALU_ADD;
                o_alu.a  = tlzd_pkg::ALU_W'(r_gather[15:0]);
                o_alu.b  = (r_phase == PH_OFF8) ? tlzd_pkg::ALU_W'(tlzd_pkg::OFF_BASE8)
                                                : tlzd_pkg::ALU_W'(tlzd_pkg::OFF_BASE16);
                n_off    = {i_alu.res[16:0], 1'b0};
                n_gather = '0;
                n_state  = S_CHK;
            end

            S_CHK: begin
                // offset reaching before the frame start is an error
                if (i_alu.carry) begin
                    n_pend.value  = '0;
                    n_pend.index  = r_wp[tlzd_pkg::IDX_W-1:0];
                    n_pend.done   = 1'b1;
                    n_pend.status = off_status;
                    n_pend_v      = 1'b1;
                    n_err         = 1'b1;
                    n_state       = S_END;
                end else begin
                    n_act   = ACT_COPY;
                    n_state = S_RUN;
                end
            end

            S_RUN: begin
                case (r_act)
                    ACT_TOP: begin
                        o_alu.a = tlzd_pkg::ALU_W'(i_total);
                        o_alu.b = tlzd_pkg::ALU_W'(r_wp);
                        if (i_alu.carry || (i_alu.res[tlzd_pkg::ALU_W-1:1] == '0)) begin
                            n_done  = 1'b1;
                            n_state = S_END;
                        end else begin
                            n_act = ACT_CODE;
                        end
                    end
                    ACT_CODE: begin
                        if (r_codes == 5'd0) begin
                            n_phase = PH_CTRL;
                            n_state = S_END;
                        end else begin
                            n_ctrl  = {2'b00, r_ctrl[31:2]};
                            n_codes = r_codes - 5'd1;
                            case (r_ctrl[1:0])
                                2'd0: begin
                                    if (r_nest == 2'd0) begin
                                        n_nest = 2'd1;
                                    end else begin
                                        n_phase = PH_LIT;
                                        n_state = S_END;
                                    end
                                end
                                2'd1: begin
                                    n_off = tlzd_pkg::OFF_W'(tlzd_pkg::OFF_CODE1);
                                    n_act = ACT_COPY;
                                end
                                2'd2: begin
                                    n_phase = PH_OFF8;
                                    n_state = S_END;
                                end
                                default: begin
                                    n_phase = PH_OFF16;
                                    n_state = S_END;
                                end
                            endcase
                        end
                    end
                    ACT_COPY: begin
                        n_act   = (r_nest == 2'd0) ? ACT_COPY2 : ACT_NEST;
                        n_state = S_RD;
                    end
                    ACT_COPY2: begin
                        n_act   = ACT_TOP;
                        n_state = S_RD;
                    end
                    ACT_NEST: begin
                        if (r_nest == 2'd1) begin
                            n_nest = 2'd2;
                            n_act  = ACT_CODE;
                        end else begin
                            n_nest = 2'd0;
                            n_act  = ACT_TOP;
                        end
                    end
                    default: n_state = S_END;
                endcase
            end

            S_RD: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = i_alu.res[tlzd_pkg::POS_W-1:0];
                n_from_mem    = 1'b1;
                n_state       = S_PUT;
            end

            S_PUT: begin
                o_res_valid = r_pend_v;
                if (!r_pend_v || i_res_ready) begin
                    o_mem.wr_en   = pos_ok;
                    o_mem.wr_addr = r_wp;
                    o_mem.wr_data = put_value;
                    n_pend.value  = put_value;
                    n_pend.index  = r_wp[tlzd_pkg::IDX_W-1:0];
                    n_pend.done   = 1'b0;
                    n_pend.status = tlzd_pkg::ST_OK;
                    n_pend_v      = 1'b1;
                    n_wp          = r_wp + 19'd1;
                    n_state       = (r_act == ACT_END) ? S_END : S_RUN;
                end
            end

            S_END: begin
                o_res_valid = r_pend_v;
                o_res.done  = r_pend.done | r_done;
                if (r_pend_v) begin
                    if (i_res_ready) begin
                        n_pend_v = 1'b0;
                    end
                end else if (r_err || r_done) begin
                    if (r_end) begin
                        n_wp     = '0;
                        n_off    = '0;
                        n_ctrl   = '0;
                        n_codes  = '0;
                        n_gather = '0;
                        n_gc     = '0;
                        n_phase  = PH_HDR0;
                        n_nest   = '0;
                    end else begin
                        n_phase = PH_DRAIN;
                    end
                    n_state = S_IN;
                end else if (r_end) begin
                    // stream ran out while more bytes were still needed
                    n_pend.value  = '0;
                    n_pend.index  = r_wp[tlzd_pkg::IDX_W-1:0];
                    n_pend.done   = 1'b1;
                    n_pend.status = end_status;
                    n_pend_v      = 1'b1;
                    n_err         = 1'b1;
                end else begin
                    n_state = S_IN;
                end
            end

            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IN;
            r_phase    <= PH_HDR0;
            r_act      <= ACT_TOP;
            r_wp       <= '0;
            r_off      <= '0;
            r_ctrl     <= '0;
            r_codes    <= '0;
            r_gather   <= '0;
            r_gc       <= '0;
            r_nest     <= '0;
            r_end      <= 1'b0;
            r_done     <= 1'b0;
            r_err      <= 1'b0;
            r_pend_v   <= 1'b0;
            r_from_mem <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_act      <= n_act;
            r_wp       <= n_wp;
            r_off      <= n_off;
            r_ctrl     <= n_ctrl;
            r_codes    <= n_codes;
            r_gather   <= n_gather;
            r_gc       <= n_gc;
            r_nest     <= n_nest;
            r_end      <= n_end;
            r_done     <= n_done;
            r_err      <= n_err;
            r_pend_v   <= n_pend_v;
            r_from_mem <= n_from_mem;
        end
        r_pend <= n_pend;
        r_val  <= n_val;
    end

endmodule

`default_nettype wire
